[src/ppm_pkg.sv]
// shared types and constants for the pedal plausibility monitor
package ppm_pkg;

	localparam int RAW_W    = 12;
	localparam int PSI_W    = 16;
	localparam int TIME_W   = 32;
	localparam int POS_W    = 8;
	localparam int THR_W    = 8;
	localparam int DLY_W    = 16;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 5;
	localparam int STEP_W   = $clog2(POS_W);

	localparam logic [RAW_W-1:0] LEFT_MIN_RST         = 12'd2700;
	localparam logic [RAW_W-1:0] LEFT_MAX_RST         = 12'd3280;
	localparam logic [RAW_W-1:0] RIGHT_MIN_RST        = 12'd480;
	localparam logic [RAW_W-1:0] RIGHT_MAX_RST        = 12'd1180;
	localparam logic [THR_W-1:0] DIFF_THRESHOLD_RST   = 8'd50;
	localparam logic [DLY_W-1:0] DISAGREE_TIME_RST    = 16'd100;
	localparam logic [POS_W-1:0] BRAKE_SET_RST        = 8'd63;
	localparam logic [POS_W-1:0] BRAKE_CLEAR_RST      = 8'd12;

	typedef struct packed {
		logic [RAW_W-1:0]  left_raw;
		logic [RAW_W-1:0]  right_raw;
		logic [PSI_W-1:0]  rear_brake_psi;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic [POS_W-1:0] left_pos;
		logic [POS_W-1:0] right_pos;
		logic [POS_W-1:0] throttle_pos;
		logic             throttle_implausible;
		logic             brake_implausible;
	} result_t;

	typedef struct packed {
		logic [RAW_W-1:0] left_min;
		logic [RAW_W-1:0] left_max;
		logic [RAW_W-1:0] right_min;
		logic [RAW_W-1:0] right_max;
		logic [THR_W-1:0] diff_threshold;
		logic [DLY_W-1:0] disagree_time_ms;
		logic [POS_W-1:0] brake_set_throttle;
		logic [POS_W-1:0] brake_clear_throttle;
	} cfg_t;

	typedef enum logic {
		CHAN_LEFT  = 1'b0,
		CHAN_RIGHT = 1'b1
	} chan_t;

	typedef struct packed {
		logic  load;
		logic  prep;
		logic  step;
		logic  store;
		logic  eval;
		chan_t chan;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctrl_sts_t;

endpackage

[src/ppm_regs.sv]
// apb configuration register bank
module ppm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppm_pkg::ADDR_W-1:0]  paddr,
	input  logic [ppm_pkg::DATA_W-1:0]  pwdata,
	output logic [ppm_pkg::DATA_W-1:0]  prdata,
	output ppm_pkg::cfg_t               cfg
);
	import ppm_pkg::*;

	typedef enum logic [2:0] {
		REG_LEFT_MIN     = 3'd0,
		REG_LEFT_MAX     = 3'd1,
		REG_RIGHT_MIN    = 3'd2,
		REG_RIGHT_MAX    = 3'd3,
		REG_DIFF_THR     = 3'd4,
		REG_DISAGREE_MS  = 3'd5,
		REG_BRAKE_SET    = 3'd6,
		REG_BRAKE_CLEAR  = 3'd7
	} reg_idx_t;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	// byte address, one word per register
	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_min             <= LEFT_MIN_RST;
			cfg_q.left_max             <= LEFT_MAX_RST;
			cfg_q.right_min            <= RIGHT_MIN_RST;
			cfg_q.right_max            <= RIGHT_MAX_RST;
			cfg_q.diff_threshold       <= DIFF_THRESHOLD_RST;
			cfg_q.disagree_time_ms     <= DISAGREE_TIME_RST;
			cfg_q.brake_set_throttle   <= BRAKE_SET_RST;
			cfg_q.brake_clear_throttle <= BRAKE_CLEAR_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_LEFT_MIN:    cfg_q.left_min             <= pwdata[RAW_W-1:0];
				REG_LEFT_MAX:    cfg_q.left_max             <= pwdata[RAW_W-1:0];
				REG_RIGHT_MIN:   cfg_q.right_min            <= pwdata[RAW_W-1:0];
				REG_RIGHT_MAX:   cfg_q.right_max            <= pwdata[RAW_W-1:0];
				REG_DIFF_THR:    cfg_q.diff_threshold       <= pwdata[THR_W-1:0];
				REG_DISAGREE_MS: cfg_q.disagree_time_ms     <= pwdata[DLY_W-1:0];
				REG_BRAKE_SET:   cfg_q.brake_set_throttle   <= pwdata[POS_W-1:0];
				REG_BRAKE_CLEAR: cfg_q.brake_clear_throttle <= pwdata[POS_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LEFT_MIN:    prdata = DATA_W'(cfg_q.left_min);
			REG_LEFT_MAX:    prdata = DATA_W'(cfg_q.left_max);
			REG_RIGHT_MIN:   prdata = DATA_W'(cfg_q.right_min);
			REG_RIGHT_MAX:   prdata = DATA_W'(cfg_q.right_max);
			REG_DIFF_THR:    prdata = DATA_W'(cfg_q.diff_threshold);
			REG_DISAGREE_MS: prdata = DATA_W'(cfg_q.disagree_time_ms);
			REG_BRAKE_SET:   prdata = DATA_W'(cfg_q.brake_set_throttle);
			REG_BRAKE_CLEAR: prdata = DATA_W'(cfg_q.brake_clear_throttle);
		endcase
	end

endmodule

[src/ppm_ctrl.sv]
// sequencing state machine for the two scaling divisions and the evaluation
module ppm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	input  ppm_pkg::ctrl_sts_t     sts,
	output ppm_pkg::ctrl_cmd_t     cmd,
	output logic                   busy
);
	import ppm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_STORE,
		S_EVAL
	} state_t;

	state_t              state_q;
	chan_t               chan_q;
	logic [STEP_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chan_q  <= CHAN_LEFT;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_PREP;
						chan_q  <= CHAN_LEFT;
					end
				end
				S_PREP: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(POS_W - 1)) state_q <= S_STORE;
				end
				S_STORE: begin
					if (chan_q == CHAN_LEFT) begin
						chan_q  <= CHAN_RIGHT;
						state_q <= S_PREP;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					// hold here while the previous result is still waiting
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load  = (state_q == S_IDLE) && sample_valid;
		cmd.prep  = (state_q == S_PREP);
		cmd.step  = (state_q == S_DIV);
		cmd.store = (state_q == S_STORE);
		cmd.eval  = (state_q == S_EVAL) && sts.out_free;
		cmd.chan  = chan_q;
	end

	assign busy = (state_q != S_IDLE);

endmodule

[src/ppm_dp.sv]
// datapath: sample capture, range scaling with a shared divider, plausibility logic
module ppm_dp #(
	parameter int ADC_BITS         = 12,
	parameter int BRAKE_ACTIVE_PSI = 100
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppm_pkg::ctrl_cmd_t   cmd,
	output ppm_pkg::ctrl_sts_t   sts,
	input  ppm_pkg::sample_t     sample,
	input  ppm_pkg::cfg_t        cfg,
	output logic                 result_valid,
	input  logic                 result_stall,
	output ppm_pkg::result_t     result
);
	import ppm_pkg::*;

	// effective sample width: samples arrive as 12 bits and are cut to ADC_BITS when that is smaller
	localparam int AW = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;

	sample_t            smp_q;
	logic [AW-1:0]      rem_q;
	logic [AW-1:0]      den_q;
	logic [POS_W-1:0]   low_q;
	logic [POS_W-1:0]   quo_q;
	logic               empty_q;
	logic [POS_W-1:0]   lpos_q;
	logic [POS_W-1:0]   rpos_q;
	logic [TIME_W-1:0]  last_agree_q;
	logic               latch_q;
	logic               out_valid_q;
	result_t            out_q;

	// operand selection and clamping for the division set-up
	logic [AW-1:0]      x_raw, lo, hi, x_clamp, dx;
	logic [AW+POS_W-1:0] num;
	logic               empty;

	always_comb begin
		if (cmd.chan == CHAN_LEFT) begin
			x_raw = smp_q.left_raw[AW-1:0];
			lo    = cfg.left_min[AW-1:0];
			hi    = cfg.left_max[AW-1:0];
		end else begin
			x_raw = smp_q.right_raw[AW-1:0];
			lo    = cfg.right_min[AW-1:0];
			hi    = cfg.right_max[AW-1:0];
		end
		empty = (hi <= lo);
		priority if (x_raw < lo) x_clamp = lo;
		else if (x_raw > hi)     x_clamp = hi;
		else                     x_clamp = x_raw;
		dx  = x_clamp - lo;
		// dx * 255 as a shift and subtract
		num = {dx, {POS_W{1'b0}}} - (AW+POS_W)'(dx);
	end

	// one restoring step; quotient is below 256 so only the low byte is shifted in
	logic [AW:0] trial;
	logic [AW:0] trial_sub;
	logic        ge;

	always_comb begin
		trial     = {rem_q, low_q[POS_W-1]};
		trial_sub = trial - {1'b0, den_q};
		ge        = (trial >= {1'b0, den_q});
	end

	// evaluation of one finished sample
	logic [POS_W-1:0]  diff;
	logic [POS_W-1:0]  pmin;
	logic [TIME_W-1:0] elapsed;
	logic              agree;
	logic              flag;
	logic [POS_W-1:0]  tp;
	logic              latch_nxt;

	always_comb begin
		diff    = (lpos_q > rpos_q) ? (lpos_q - rpos_q) : (rpos_q - lpos_q);
		pmin    = (lpos_q < rpos_q) ? lpos_q : rpos_q;
		agree   = (diff < cfg.diff_threshold);
		elapsed = smp_q.now_ms - last_agree_q;
		flag    = !agree && (elapsed >= TIME_W'(cfg.disagree_time_ms));
		tp      = flag ? '0 : pmin;
		// set wins over clear
		priority if (tp > cfg.brake_set_throttle &&
		             smp_q.rear_brake_psi > PSI_W'(BRAKE_ACTIVE_PSI))
			latch_nxt = 1'b1;
		else if (tp < cfg.brake_clear_throttle)
			latch_nxt = 1'b0;
		else
			latch_nxt = latch_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) smp_q <= sample;
		if (cmd.prep) begin
			rem_q   <= num[AW+POS_W-1:POS_W];
			low_q   <= num[POS_W-1:0];
			den_q   <= hi - lo;
			empty_q <= empty;
		end
		if (cmd.step) begin
			rem_q <= ge ? trial_sub[AW-1:0] : trial[AW-1:0];
			low_q <= {low_q[POS_W-2:0], 1'b0};
			quo_q <= {quo_q[POS_W-2:0], ge};
		end
		if (cmd.store) begin
			if (cmd.chan == CHAN_LEFT) lpos_q <= empty_q ? '0 : quo_q;
			else                       rpos_q <= empty_q ? '0 : quo_q;
		end
		if (cmd.eval) begin
			out_q.left_pos             <= lpos_q;
			out_q.right_pos            <= rpos_q;
			out_q.throttle_pos         <= tp;
			out_q.throttle_implausible <= flag;
			out_q.brake_implausible    <= latch_nxt;
		end
	end

	// state and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_agree_q <= '0;
			latch_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.eval) begin
				if (agree) last_agree_q <= smp_q.now_ms;
				latch_q     <= latch_nxt;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free  = !out_valid_q;
	assign result_valid  = out_valid_q;
	assign result        = out_q;

endmodule

[src/pedal_plausibility_monitor.sv]
// pedal plausibility monitor top level
//
//  channel   direction  handshake                      beat
//  sample    in         sample_valid / sample_stall    ppm_pkg::sample_t
//  result    out        result_valid / result_stall    ppm_pkg::result_t
//  apb cfg   in/out     psel penable pwrite pready     32 bit word per register
//
// a sample beat is accepted only while the block is idle, and the next sample
// is taken after its result is evaluated; the scaling is done by the
// single 8-step divider that scales the left and then the right sensor
// reset clears the agreement time, the brake latch and all handshake state
// a stalled result does not block the next sample; only its evaluation waits
module pedal_plausibility_monitor #(
	parameter int ADC_BITS         = 12,
	parameter int BRAKE_ACTIVE_PSI = 100
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  ppm_pkg::sample_t            sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output ppm_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppm_pkg::ADDR_W-1:0]  paddr,
	input  logic [ppm_pkg::DATA_W-1:0]  pwdata,
	output logic [ppm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import ppm_pkg::*;

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	ctrl_sts_t  sts;
	logic       busy;

	assign pready       = 1'b1;
	assign sample_stall = busy;

	ppm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ppm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy)
	);

	ppm_dp #(
		.ADC_BITS         (ADC_BITS),
		.BRAKE_ACTIVE_PSI (BRAKE_ACTIVE_PSI)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample),
		.cfg          (cfg),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[src/ppm_checker.sv]
// port-level checks for the pedal plausibility monitor, bound to the top level
module ppm_port_checks (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        sample_valid,
	input logic                        sample_stall,
	input logic                        result_valid,
	input logic                        result_stall,
	input ppm_pkg::result_t            result
);
	import ppm_pkg::*;

	// a held result beat keeps its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// the block works on one sample at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("second sample taken while one is in work");

	// implausible throttle forces zero position
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.throttle_implausible |-> result.throttle_pos == '0)
		else $error("throttle position not zero while implausible");

	// otherwise the throttle is the smaller sensor position
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.throttle_implausible |->
			(result.throttle_pos <= result.left_pos) &&
			(result.throttle_pos <= result.right_pos) &&
			((result.throttle_pos == result.left_pos) ||
			 (result.throttle_pos == result.right_pos)))
		else $error("throttle position is not the smaller sensor position");

endmodule

bind pedal_plausibility_monitor ppm_port_checks u_ppm_port_checks (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

[verif/ppm_checker.sv]
// register map for the testbench and the result checker of the pedal plausibility monitor
`timescale 1ns / 100ps

package ppm_tb_pkg;

	typedef enum logic [2:0] {
		REG_LEFT_MIN       = 3'd0,
		REG_LEFT_MAX       = 3'd1,
		REG_RIGHT_MIN      = 3'd2,
		REG_RIGHT_MAX      = 3'd3,
		REG_DIFF_THRESHOLD = 3'd4,
		REG_DISAGREE_TIME  = 3'd5,
		REG_BRAKE_SET      = 3'd6,
		REG_BRAKE_CLEAR    = 3'd7
	} ppm_reg_t;

endpackage

module ppm_checker #(
	parameter int BRAKE_ACTIVE_PSI = 100
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	input  logic                        sample_stall,
	input  ppm_pkg::sample_t            sample,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  ppm_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [ppm_pkg::ADDR_W-1:0]  paddr,
	input  logic [ppm_pkg::DATA_W-1:0]  pwdata,
	input  logic [ppm_pkg::DATA_W-1:0]  prdata,
	output int                          fail_count,
	output int                          pending
);
	import ppm_pkg::*;
	import ppm_tb_pkg::*;

	cfg_t              cfg;
	logic [TIME_W-1:0] agree_ms;
	logic              brake_latch;
	result_t           due_results[$];
	result_t           due;
	ppm_reg_t          reg_sel;

	task automatic log_failure(input string msg);
		if (fail_count < 10) begin
			$display("%0t: %s", $time, msg);
		end
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (got !== want) begin
			log_failure($sformatf("%s expected %0d got %0d", name, want, got));
		end
	endtask

	function automatic logic [POS_W-1:0] scale_travel(input logic [RAW_W-1:0] raw,
			input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi);
		int unsigned x;
		if (hi <= lo) begin
			return '0;
		end
		x = 32'(raw);
		if (raw < lo) begin
			x = 32'(lo);
		end
		if (raw > hi) begin
			x = 32'(hi);
		end
		return POS_W'(((x - 32'(lo)) * 32'd255) / 32'(hi - lo));
	endfunction

	// advances the agreement time and the brake latch as the block does
	function automatic result_t next_result(input sample_t s);
		result_t          r;
		logic [POS_W-1:0] spread;
		r.left_pos = scale_travel(s.left_raw, cfg.left_min, cfg.left_max);
		r.right_pos = scale_travel(s.right_raw, cfg.right_min, cfg.right_max);
		spread = (r.left_pos > r.right_pos) ? r.left_pos - r.right_pos
			: r.right_pos - r.left_pos;
		r.throttle_implausible = 1'b0;
		if (spread < cfg.diff_threshold) begin
			agree_ms = s.now_ms;
		end else if (TIME_W'(s.now_ms - agree_ms) >= TIME_W'(cfg.disagree_time_ms)) begin
			r.throttle_implausible = 1'b1;
		end
		if (r.throttle_implausible) begin
			r.throttle_pos = '0;
		end else begin
			r.throttle_pos = (r.left_pos < r.right_pos) ? r.left_pos : r.right_pos;
		end
		// setting wins when both thresholds are met
		if (r.throttle_pos > cfg.brake_set_throttle &&
				s.rear_brake_psi > PSI_W'(BRAKE_ACTIVE_PSI)) begin
			brake_latch = 1'b1;
		end else if (r.throttle_pos < cfg.brake_clear_throttle) begin
			brake_latch = 1'b0;
		end
		r.brake_implausible = brake_latch;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] reg_word(input ppm_reg_t idx);
		case (idx)
			REG_LEFT_MIN:       return DATA_W'(cfg.left_min);
			REG_LEFT_MAX:       return DATA_W'(cfg.left_max);
			REG_RIGHT_MIN:      return DATA_W'(cfg.right_min);
			REG_RIGHT_MAX:      return DATA_W'(cfg.right_max);
			REG_DIFF_THRESHOLD: return DATA_W'(cfg.diff_threshold);
			REG_DISAGREE_TIME:  return DATA_W'(cfg.disagree_time_ms);
			REG_BRAKE_SET:      return DATA_W'(cfg.brake_set_throttle);
			default:            return DATA_W'(cfg.brake_clear_throttle);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = cfg_t'{LEFT_MIN_RST, LEFT_MAX_RST, RIGHT_MIN_RST, RIGHT_MAX_RST,
				DIFF_THRESHOLD_RST, DISAGREE_TIME_RST, BRAKE_SET_RST, BRAKE_CLEAR_RST};
			agree_ms = '0;
			brake_latch = 1'b0;
			due_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// results are matched before this edge's sample joins the queue
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					log_failure("result beat with nothing outstanding");
				end else begin
					due = due_results.pop_front();
					check_field("left_pos", due.left_pos, result.left_pos);
					check_field("right_pos", due.right_pos, result.right_pos);
					check_field("throttle_pos", due.throttle_pos, result.throttle_pos);
					check_field("throttle_implausible", POS_W'(due.throttle_implausible),
						POS_W'(result.throttle_implausible));
					check_field("brake_implausible", POS_W'(due.brake_implausible),
						POS_W'(result.brake_implausible));
				end
			end
			if (sample_valid && !sample_stall) begin
				due_results.push_back(next_result(sample));
			end
			if (psel && penable && pready) begin
				reg_sel = ppm_reg_t'(paddr[ADDR_W-1:2]);
				if (pwrite) begin
					case (reg_sel)
						REG_LEFT_MIN:       cfg.left_min = pwdata[RAW_W-1:0];
						REG_LEFT_MAX:       cfg.left_max = pwdata[RAW_W-1:0];
						REG_RIGHT_MIN:      cfg.right_min = pwdata[RAW_W-1:0];
						REG_RIGHT_MAX:      cfg.right_max = pwdata[RAW_W-1:0];
						REG_DIFF_THRESHOLD: cfg.diff_threshold = pwdata[THR_W-1:0];
						REG_DISAGREE_TIME:  cfg.disagree_time_ms = pwdata[DLY_W-1:0];
						REG_BRAKE_SET:      cfg.brake_set_throttle = pwdata[POS_W-1:0];
						default:            cfg.brake_clear_throttle = pwdata[POS_W-1:0];
					endcase
				end else if (prdata !== reg_word(reg_sel)) begin
					log_failure($sformatf("register %s read expected %0d got %0d",
						reg_sel.name(), reg_word(reg_sel), prdata));
				end
			end
			pending = due_results.size();
		end
	end

endmodule

[verif/tb_pedal_plausibility_monitor.sv]
// stimulus, clock, reset and verdict for the pedal plausibility monitor
`timescale 1ns / 100ps

module tb_pedal_plausibility_monitor;
	import ppm_pkg::*;
	import ppm_tb_pkg::*;

	localparam int PSI_ACTIVE      = 100;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 116;
	localparam int SETTLE_CYCLES   = 25;

	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_stall;
	sample_t           sample;
	logic              result_valid;
	logic              result_stall;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending;

	bit                idle_on;
	cfg_t              cur_cfg;
	logic [TIME_W-1:0] clock_ms;
	bit                split;

	pedal_plausibility_monitor #(
		.BRAKE_ACTIVE_PSI(PSI_ACTIVE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	ppm_checker #(
		.BRAKE_ACTIVE_PSI(PSI_ACTIVE)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver back-pressure in bursts
	initial begin
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			result_stall <= 1'b0;
		end
	end

	task automatic send_sample(input logic [RAW_W-1:0] l, input logic [RAW_W-1:0] r,
			input logic [PSI_W-1:0] psi, input logic [TIME_W-1:0] now);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		sample <= sample_t'{l, r, psi, now};
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
	endtask

	// hold off until every outstanding beat has come back
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_access(input ppm_reg_t idx, input bit wr, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic readback_regs();
		for (int i = REG_LEFT_MIN; i <= REG_BRAKE_CLEAR; i++) begin
			apb_access(ppm_reg_t'(i), 1'b0, '0);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// unused upper data bits carry noise when scramble is set
	task automatic load_config(input cfg_t c, input bit scramble);
		logic [DATA_W-1:0] fill;
		fill = scramble ? DATA_W'($urandom) : '0;
		cur_cfg = c;
		apb_access(REG_LEFT_MIN, 1'b1, {fill[DATA_W-1:RAW_W], c.left_min});
		apb_access(REG_LEFT_MAX, 1'b1, {fill[DATA_W-1:RAW_W], c.left_max});
		apb_access(REG_RIGHT_MIN, 1'b1, {fill[DATA_W-1:RAW_W], c.right_min});
		apb_access(REG_RIGHT_MAX, 1'b1, {fill[DATA_W-1:RAW_W], c.right_max});
		apb_access(REG_DIFF_THRESHOLD, 1'b1, {fill[DATA_W-1:THR_W], c.diff_threshold});
		apb_access(REG_DISAGREE_TIME, 1'b1, {fill[DATA_W-1:DLY_W], c.disagree_time_ms});
		apb_access(REG_BRAKE_SET, 1'b1, {fill[DATA_W-1:POS_W], c.brake_set_throttle});
		apb_access(REG_BRAKE_CLEAR, 1'b1, {fill[DATA_W-1:POS_W], c.brake_clear_throttle});
		readback_regs();
	endtask

	function automatic void pick_range(output logic [RAW_W-1:0] lo, output logic [RAW_W-1:0] hi);
		case ($urandom_range(0, 9))
			0: begin
				lo = '0;
				hi = '1;
			end
			1: begin
				lo = RAW_W'($urandom_range(0, 4095));
				hi = lo;
			end
			2: begin
				lo = RAW_W'($urandom_range(1, 4095));
				hi = RAW_W'($urandom_range(0, lo - 1));
			end
			default: begin
				lo = RAW_W'($urandom_range(0, 3800));
				hi = RAW_W'(lo + $urandom_range(1, 4095 - lo));
			end
		endcase
	endfunction

	function automatic int unsigned pick_value(input int unsigned top_v, input int unsigned lo_r,
			input int unsigned hi_r);
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return top_v;
			default: return $urandom_range(lo_r, hi_r);
		endcase
	endfunction

	// raw reading for a wanted travel, sometimes anything to hit the clamps
	function automatic logic [RAW_W-1:0] to_raw(input int unsigned pos,
			input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi);
		if (hi <= lo || $urandom_range(0, 9) == 0) begin
			return RAW_W'($urandom_range(0, 4095));
		end
		return RAW_W'(lo + (pos * (hi - lo) + 127) / 255);
	endfunction

	initial begin
		cfg_t              c;
		int unsigned       pos;
		int unsigned       rpos;
		int unsigned       gap;
		int unsigned       step_max;
		logic [PSI_W-1:0]  psi;

		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b1;
		split = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		cur_cfg = cfg_t'{LEFT_MIN_RST, LEFT_MAX_RST, RIGHT_MIN_RST, RIGHT_MAX_RST,
			DIFF_THRESHOLD_RST, DISAGREE_TIME_RST, BRAKE_SET_RST, BRAKE_CLEAR_RST};
		readback_regs();

		// reset settings: range ends, brake pressure either side of active
		send_sample(12'd0, 12'd0, 16'd0, 32'd0);
		send_sample(12'd4095, 12'd4095, 16'hFFFF, 32'd5);
		send_sample(12'd2700, 12'd480, 16'd101, 32'd10);
		send_sample(12'd3280, 12'd1180, 16'd100, 32'd20);
		// disagreement held until the time limit is just reached
		send_sample(12'd4095, 12'd0, 16'd0, 32'd30);
		send_sample(12'd4095, 12'd0, 16'd0, 32'd119);
		send_sample(12'd4095, 12'd0, 16'd0, 32'd120);
		send_sample(12'd2990, 12'd830, 16'd0, 32'd121);
		// elapsed time across the wrap of the millisecond counter
		send_sample(12'd2990, 12'd830, 16'd0, 32'hFFFF_FFF0);
		send_sample(12'd4095, 12'd0, 16'd0, 32'h0000_0050);
		send_sample(12'd4095, 12'd0, 16'd0, 32'h0000_0054);
		drain();

		// brake set and clear thresholds met together
		c = cur_cfg;
		c.brake_set_throttle = 8'd10;
		c.brake_clear_throttle = 8'd200;
		load_config(c, 1'b0);
		send_sample(12'd2990, 12'd830, 16'd200, 32'd200);
		send_sample(12'd2990, 12'd830, 16'd50, 32'd210);
		drain();

		// empty and inverted ranges, zero threshold and zero time
		c = cfg_t'{12'd2000, 12'd2000, 12'd4095, 12'd0, 8'd0, 16'd0, 8'd0, 8'd255};
		load_config(c, 1'b0);
		send_sample(12'd2000, 12'd4095, 16'd500, 32'd300);
		send_sample(12'd0, 12'd0, 16'd0, 32'd301);
		send_sample(12'd4095, 12'd4095, 16'hFFFF, 32'd302);
		drain();

		// full ranges, widest threshold, longest disagreement time
		c = cfg_t'{12'd0, 12'd4095, 12'd0, 12'd4095, 8'd255, 16'hFFFF, 8'd10, 8'd200};
		load_config(c, 1'b0);
		send_sample(12'd2048, 12'd2048, 16'd200, 32'd1000);
		send_sample(12'd4095, 12'd0, 16'd200, 32'd1000 + 32'd65534);
		send_sample(12'd4095, 12'd0, 16'd0, 32'd1000 + 32'd65535);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			idle_on = (phase != PHASES - 1) && (phase % 3 != 2);
			pick_range(c.left_min, c.left_max);
			pick_range(c.right_min, c.right_max);
			c.diff_threshold = THR_W'(pick_value(255, 1, 80));
			c.disagree_time_ms = DLY_W'(($urandom_range(0, 7) == 0) ? 16'hFFFF
				: pick_value(0, 1, 300));
			c.brake_set_throttle = POS_W'(pick_value(255, 20, 200));
			c.brake_clear_throttle = POS_W'(pick_value(255, 0, 60));
			load_config(c, 1'b1);
			clock_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
				: TIME_W'($urandom);
			step_max = c.disagree_time_ms / 6 + 2;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 7) == 0) begin
					split = !split;
				end
				pos = $urandom_range(0, 255);
				gap = split ? c.diff_threshold + $urandom_range(0, 40)
					: $urandom_range(0, c.diff_threshold / 2);
				if ($urandom_range(0, 1) == 1) begin
					rpos = (pos + gap > 255) ? 255 : pos + gap;
				end else begin
					rpos = (pos < gap) ? 0 : pos - gap;
				end
				psi = ($urandom_range(0, 2) == 0) ? PSI_W'($urandom)
					: PSI_W'($urandom_range(60, 140));
				clock_ms = clock_ms + $urandom_range(0, step_max);
				if ($urandom_range(0, 7) == 0) begin
					send_sample(RAW_W'($urandom), RAW_W'($urandom), psi, TIME_W'($urandom));
				end else begin
					send_sample(to_raw(pos, c.left_min, c.left_max),
						to_raw(rpos, c.right_min, c.right_max), psi, clock_ms);
				end
			end
		end
		drain();

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[pedal_plausibility_monitor.f]
src/ppm_pkg.sv
src/ppm_regs.sv
src/ppm_ctrl.sv
src/ppm_dp.sv
src/pedal_plausibility_monitor.sv
src/ppm_checker.sv
verif/ppm_checker.sv
verif/tb_pedal_plausibility_monitor.sv
